// ===== src/atcm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atcm_pkg
// Shared types, field widths and codes for the agent table matcher.
// ----------------------------------------------------------------------------
package atcm_pkg;

    // fixed widths of the request and response fields
    localparam int MODE_W      = 2;
    localparam int WORKER_ID_W = 32;
    localparam int HANDLE_W    = 16;
    localparam int MEMORY_W    = 20;
    localparam int CAPS_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 4;
    localparam int TOTAL_W     = 5;

    // defaults for the top-level parameters
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 32;
    localparam int DEF_CAP_BITS    = 8;

    // depth of the queue between front and back end
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [MODE_W-1:0] {
        OP_REGISTER = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_RELEASE  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    // classified request as it sits in the queue
    typedef struct packed {
        t_op                    op;
        logic [WORKER_ID_W-1:0] id;
        logic [HANDLE_W-1:0]    handle;
        logic [MEMORY_W-1:0]    memory;
        logic                   gpu;
        logic [CAPS_W-1:0]      caps;
    } t_cmd;

endpackage
`default_nettype wire

// ===== src/atcm_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atcm_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface atcm_req_if import atcm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [MODE_W-1:0]      mode;
    logic [WORKER_ID_W-1:0] worker_id;
    logic [HANDLE_W-1:0]    handle;
    logic [MEMORY_W-1:0]    agent_memory;
    logic                   agent_gpu;
    logic [CAPS_W-1:0]      agent_caps;
    logic [MEMORY_W-1:0]    need_memory;
    logic                   need_gpu;
    logic [CAPS_W-1:0]      need_caps;

    modport source (
        output valid, mode, worker_id, handle, agent_memory, agent_gpu, agent_caps,
               need_memory, need_gpu, need_caps,
        input  ready
    );
    modport sink (
        input  valid, mode, worker_id, handle, agent_memory, agent_gpu, agent_caps,
               need_memory, need_gpu, need_caps,
        output ready
    );
endinterface
`default_nettype wire

// ===== src/atcm_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atcm_rsp_if
// Response channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface atcm_rsp_if import atcm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] chosen_handle;
    logic [SLOT_W-1:0]   chosen_slot;
    logic [TOTAL_W-1:0]  agent_total;

    modport source (
        output valid, status, chosen_handle, chosen_slot, agent_total,
        input  ready
    );
    modport sink (
        input  valid, status, chosen_handle, chosen_slot, agent_total,
        output ready
    );
endinterface
`default_nettype wire

// ===== src/agent_table_capability_matcher_top.sv =====
`default_nettype none
// path: an accepted request beat enters the command queue, and the back end pops it
// into the output register as its response beat; later if queue or output backs up
// throughput: one request per cycle while responses are taken, one table update
// per command in the back end; the two-entry queue lets front and back stall apart
// reset: synchronous, clears the busy bits, the agent count, the queue and the output
// valid flag; entry contents are not cleared and are only read below the count
// ----------------------------------------------------------------------------
// agent_table_capability_matcher_top
// Agent table with register, remove, first-fit dispatch and release requests.
// ----------------------------------------------------------------------------
module agent_table_capability_matcher_top import atcm_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int CAP_BITS    = DEF_CAP_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    atcm_req_if.sink   i_req,
    atcm_rsp_if.source o_rsp
);

    logic push, full, cmd_valid, cmd_pop;
    t_cmd push_cmd, head_cmd;

    atcm_front u_front (
        .i_req  (i_req),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    atcm_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_cmd   (head_cmd),
        .i_pop   (cmd_pop)
    );

    atcm_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BITS     (ID_BITS),
        .CAP_BITS    (CAP_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_rsp       (o_rsp)
    );

endmodule
`default_nettype wire

// ===== src/atcm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atcm_front
// Accepts request beats and folds them into one command word per mode.
// ----------------------------------------------------------------------------
module atcm_front import atcm_pkg::*; (
    atcm_req_if.sink i_req,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    always_comb begin
        o_cmd.op     = t_op'(i_req.mode);
        o_cmd.id     = i_req.worker_id;
        o_cmd.handle = i_req.handle;
        o_cmd.memory = '0;
        o_cmd.gpu    = 1'b0;
        o_cmd.caps   = '0;
        unique case (t_op'(i_req.mode))
            OP_REGISTER: begin
                o_cmd.memory = i_req.agent_memory;
                o_cmd.gpu    = i_req.agent_gpu;
                o_cmd.caps   = i_req.agent_caps;
            end
            OP_DISPATCH: begin
                o_cmd.memory = i_req.need_memory;
                o_cmd.gpu    = i_req.need_gpu;
                o_cmd.caps   = i_req.need_caps;
            end
            OP_REMOVE, OP_RELEASE: begin
                // only the handle matters
                o_cmd.memory = '0;
            end
            default: begin
                o_cmd.memory = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/atcm_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atcm_cmd_fifo
// Short command queue that decouples the front end from the table engine.
// ----------------------------------------------------------------------------
module atcm_cmd_fifo import atcm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(FIFO_DEPTH);

    t_cmd             r_slot [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [LVL_W-1:0] r_level,  n_level;

    assign o_full  = (r_level == FULL_LVL);
    assign o_valid = (r_level != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_level  = r_level;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_level = r_level + 1'b1;
        end else if (!i_push && i_pop) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== src/atcm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atcm_back
// Agent table engine: parallel compare over all entries, first-hit select,
// one table update per command and a registered response.
// ----------------------------------------------------------------------------
module atcm_back import atcm_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int CAP_BITS    = DEF_CAP_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    atcm_rsp_if.source o_rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W  = (ID_BITS < WORKER_ID_W) ? ID_BITS : WORKER_ID_W;
    localparam int CAP_W = (CAP_BITS < CAPS_W) ? CAP_BITS : CAPS_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    // table contents, no reset
    logic [ID_W-1:0]     r_id     [TABLE_DEPTH];
    logic [HANDLE_W-1:0] r_handle [TABLE_DEPTH];
    logic [MEMORY_W-1:0] r_memory [TABLE_DEPTH];
    logic                r_gpu    [TABLE_DEPTH];
    logic [CAP_W-1:0]    r_caps   [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] r_busy, n_busy;
    logic [CNT_W-1:0]       r_count, n_count;

    logic                r_out_valid;
    t_status             r_status, n_status;
    logic [HANDLE_W-1:0] r_chosen_handle, n_chosen_handle;
    logic [SLOT_W-1:0]   r_chosen_slot, n_chosen_slot;
    logic [TOTAL_W-1:0]  r_total, n_total;

    logic [ID_W-1:0]        cmd_id;
    logic [CAP_W-1:0]       cmd_caps;
    logic [TABLE_DEPTH-1:0] id_hit, handle_hit, fit, sel;
    logic                   any_hit;
    logic [IDX_W-1:0]       hit_idx, last_idx, act_idx;
    logic [CNT_W-1:0]       count_m1;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [ID_W-1:0]     wr_id;
    logic [HANDLE_W-1:0] wr_handle;
    logic [MEMORY_W-1:0] wr_memory;
    logic                wr_gpu;
    logic [CAP_W-1:0]    wr_caps;

    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [CNT_W+TOTAL_W-1:0] total_ext;

    assign cmd_id   = i_cmd.id[ID_W-1:0];
    assign cmd_caps = i_cmd.caps[CAP_W-1:0];
    assign count_m1 = r_count - 1'b1;
    assign last_idx = count_m1[IDX_W-1:0];

    assign o_cmd_pop = i_cmd_valid && (!r_out_valid || o_rsp.ready);

    // per-entry compares, all in parallel
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            logic live;
            live          = CNT_W'(i) < r_count;
            id_hit[i]     = live && (r_id[i] == cmd_id);
            handle_hit[i] = live && (r_handle[i] == i_cmd.handle);
            fit[i]        = live && !r_busy[i] && (r_memory[i] >= i_cmd.memory)
                            && (!i_cmd.gpu || r_gpu[i])
                            && ((r_caps[i] & cmd_caps) == cmd_caps);
        end
    end

    assign sel     = (i_cmd.op == OP_DISPATCH) ? fit : handle_hit;
    assign any_hit = |sel;

    // lowest set position wins
    always_comb begin
        hit_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (sel[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_busy          = r_busy;
        n_count         = r_count;
        n_status        = ST_MISS;
        n_chosen_handle = '0;
        act_idx         = '0;
        wr_en           = 1'b0;
        wr_idx          = hit_idx;
        wr_id           = cmd_id;
        wr_handle       = i_cmd.handle;
        wr_memory       = i_cmd.memory;
        wr_gpu          = i_cmd.gpu;
        wr_caps         = cmd_caps;
        unique case (i_cmd.op)
            OP_REGISTER: begin
                if (|id_hit) begin
                    n_status = ST_DUP;
                end else if (r_count == FULL_COUNT) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en           = 1'b1;
                    wr_idx          = r_count[IDX_W-1:0];
                    n_busy[wr_idx]  = 1'b0;
                    n_count         = r_count + 1'b1;
                    n_status        = ST_DONE;
                    n_chosen_handle = i_cmd.handle;
                    act_idx         = wr_idx;
                end
            end
            OP_REMOVE: begin
                if (any_hit) begin
                    // last entry moves into the hole, busy bit included
                    wr_en           = 1'b1;
                    wr_id           = r_id[last_idx];
                    wr_handle       = r_handle[last_idx];
                    wr_memory       = r_memory[last_idx];
                    wr_gpu          = r_gpu[last_idx];
                    wr_caps         = r_caps[last_idx];
                    n_busy[hit_idx] = r_busy[last_idx];
                    n_count         = count_m1;
                    n_status        = ST_DONE;
                    n_chosen_handle = i_cmd.handle;
                    act_idx         = hit_idx;
                end
            end
            OP_DISPATCH: begin
                if (any_hit) begin
                    n_busy[hit_idx] = 1'b1;
                    n_status        = ST_DONE;
                    n_chosen_handle = r_handle[hit_idx];
                    act_idx         = hit_idx;
                end
            end
            OP_RELEASE: begin
                if (any_hit) begin
                    n_busy[hit_idx] = 1'b0;
                    n_status        = ST_DONE;
                    n_chosen_handle = i_cmd.handle;
                    act_idx         = hit_idx;
                end
            end
            default: begin
                n_status = ST_MISS;
            end
        endcase
    end

    assign slot_ext      = {{SLOT_W{1'b0}}, act_idx};
    assign n_chosen_slot = slot_ext[SLOT_W-1:0];
    assign total_ext     = {{TOTAL_W{1'b0}}, n_count};
    assign n_total       = total_ext[TOTAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_busy      <= n_busy;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_status        <= n_status;
            r_chosen_handle <= n_chosen_handle;
            r_chosen_slot   <= n_chosen_slot;
            r_total         <= n_total;
        end
        if (o_cmd_pop && wr_en) begin
            r_id[wr_idx]     <= wr_id;
            r_handle[wr_idx] <= wr_handle;
            r_memory[wr_idx] <= wr_memory;
            r_gpu[wr_idx]    <= wr_gpu;
            r_caps[wr_idx]   <= wr_caps;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.chosen_handle = r_chosen_handle;
    assign o_rsp.chosen_slot   = r_chosen_slot;
    assign o_rsp.agent_total   = r_total;

endmodule
`default_nettype wire

// ===== dv/tb_agent_table_capability_matcher_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_agent_table_capability_matcher_top
// Self-checking bench for the agent table matcher. A directed table walks the
// empty table, the extremes, the full table and the special cases, then
// phased random traffic fills, churns and drains the table. Every response
// beat is compared field by field with a typed row or a behavioural model.
// ----------------------------------------------------------------------------
module tb_agent_table_capability_matcher_top;
    timeunit 1ns;
    timeprecision 1ps;

    import atcm_pkg::*;

    localparam int DEPTH          = DEF_TABLE_DEPTH;
    localparam int N_RANDOM       = 750;
    localparam int PHASE_LEN      = 50;
    localparam int HOLD_PHASE     = 2;
    localparam int PAUSE_PHASE    = 8;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        t_op                    op;
        logic [WORKER_ID_W-1:0] id;
        logic [HANDLE_W-1:0]    handle;
        logic [MEMORY_W-1:0]    agent_memory;
        logic                   agent_gpu;
        logic [CAPS_W-1:0]      agent_caps;
        logic [MEMORY_W-1:0]    need_memory;
        logic                   need_gpu;
        logic [CAPS_W-1:0]      need_caps;
    } t_tb_req;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] handle;
        logic [SLOT_W-1:0]   slot;
        logic [TOTAL_W-1:0]  total;
    } t_tb_rsp;

    // a directed row may carry a response typed in by hand
    typedef struct packed {
        logic    typed;
        t_tb_rsp rsp;
    } t_rsp_hint;

    typedef struct packed {
        t_tb_req   req;
        t_rsp_hint hint;
    } t_dir_row;

    bit   clk;
    logic rst_n;

    atcm_req_if req_if ();
    atcm_rsp_if rsp_if ();

    agent_table_capability_matcher_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // model of the agent table
    logic [WORKER_ID_W-1:0] tbl_id     [DEPTH];
    logic [HANDLE_W-1:0]    tbl_handle [DEPTH];
    logic [MEMORY_W-1:0]    tbl_memory [DEPTH];
    logic                   tbl_gpu    [DEPTH];
    logic [CAPS_W-1:0]      tbl_caps   [DEPTH];
    logic                   tbl_busy   [DEPTH];
    int                     tbl_count;

    t_tb_rsp   expected_rsp_q [$];
    t_rsp_hint hint_q [$];
    t_dir_row  dir_rows [$];

    logic [HANDLE_W-1:0] handle_pool [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0002,
                                             16'h0003, 16'h8000, 16'h00FF, 16'h1234};

    int err_count;
    int idle_cycles;
    bit quiet;
    bit rsp_hold_req;

    function automatic int find_slot_by_handle(logic [HANDLE_W-1:0] h);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_handle[i] == h) return i;
        return -1;
    endfunction

    function automatic t_tb_rsp table_step(t_tb_req r);
        t_tb_rsp o;
        int      idx;
        int      last;
        bit      dup;
        o.status = ST_MISS;
        o.handle = '0;
        o.slot   = '0;
        idx      = -1;
        dup      = 1'b0;
        case (r.op)
            OP_REGISTER: begin
                for (int i = 0; i < tbl_count; i++)
                    if (tbl_id[i] == r.id) dup = 1'b1;
                if (dup) begin
                    o.status = ST_DUP;
                end else if (tbl_count >= DEPTH) begin
                    o.status = ST_FULL;
                end else begin
                    idx             = tbl_count;
                    tbl_id[idx]     = r.id;
                    tbl_handle[idx] = r.handle;
                    tbl_memory[idx] = r.agent_memory;
                    tbl_gpu[idx]    = r.agent_gpu;
                    tbl_caps[idx]   = r.agent_caps;
                    tbl_busy[idx]   = 1'b0;
                    tbl_count++;
                end
            end
            OP_REMOVE: begin
                idx = find_slot_by_handle(r.handle);
                if (idx >= 0) begin
                    // last entry moves into the hole with its own busy bit
                    last            = tbl_count - 1;
                    tbl_id[idx]     = tbl_id[last];
                    tbl_handle[idx] = tbl_handle[last];
                    tbl_memory[idx] = tbl_memory[last];
                    tbl_gpu[idx]    = tbl_gpu[last];
                    tbl_caps[idx]   = tbl_caps[last];
                    tbl_busy[idx]   = tbl_busy[last];
                    tbl_count--;
                end
            end
            OP_DISPATCH: begin
                for (int i = 0; i < tbl_count && idx < 0; i++)
                    if (!tbl_busy[i] && tbl_memory[i] >= r.need_memory &&
                        (!r.need_gpu || tbl_gpu[i]) &&
                        (tbl_caps[i] & r.need_caps) == r.need_caps)
                        idx = i;
                if (idx >= 0) tbl_busy[idx] = 1'b1;
            end
            OP_RELEASE: begin
                idx = find_slot_by_handle(r.handle);
                if (idx >= 0) tbl_busy[idx] = 1'b0;
            end
            default: ;
        endcase
        if (idx >= 0) begin
            o.status = ST_DONE;
            o.handle = (r.op == OP_DISPATCH) ? tbl_handle[idx] : r.handle;
            o.slot   = idx[SLOT_W-1:0];
        end
        o.total = tbl_count[TOTAL_W-1:0];
        return o;
    endfunction

    function automatic logic [MEMORY_W-1:0] pick_memory();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return MEMORY_W'($urandom_range(0, 4095));
            default: return MEMORY_W'($urandom);
        endcase
    endfunction

    function automatic logic [CAPS_W-1:0] pick_need_caps();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return CAPS_W'(1 << $urandom_range(0, CAPS_W - 1));
            2:       return CAPS_W'($urandom & $urandom);
            default: return CAPS_W'($urandom);
        endcase
    endfunction

    // kind 0 fills the table, 1 churns it, 2 drains it
    function automatic t_tb_req random_request(int kind);
        t_tb_req r;
        int      roll;
        int      w_reg;
        int      w_rem;
        int      w_disp;
        case (kind)
            0:       begin w_reg = 55; w_rem = 65; w_disp = 85; end
            1:       begin w_reg = 25; w_rem = 45; w_disp = 80; end
            default: begin w_reg = 10; w_rem = 55; w_disp = 80; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < w_reg)       r.op = OP_REGISTER;
        else if (roll < w_rem)  r.op = OP_REMOVE;
        else if (roll < w_disp) r.op = OP_DISPATCH;
        else                    r.op = OP_RELEASE;

        // small id pool gives duplicates, full words reach every bit
        roll = $urandom_range(0, 9);
        if (roll < 6)      r.id = WORKER_ID_W'($urandom_range(0, 23));
        else if (roll < 7) r.id = '1;
        else               r.id = WORKER_ID_W'($urandom);

        roll = $urandom_range(0, 9);
        if ((r.op == OP_REMOVE || r.op == OP_RELEASE) && tbl_count > 0 && roll < 6)
            r.handle = tbl_handle[$urandom_range(0, tbl_count - 1)];
        else if (roll < 8)
            r.handle = handle_pool[$urandom_range(0, 7)];
        else
            r.handle = HANDLE_W'($urandom);

        r.agent_memory = pick_memory();
        r.agent_gpu    = 1'($urandom_range(0, 1));
        r.agent_caps   = CAPS_W'($urandom);
        r.need_memory  = pick_memory();
        r.need_gpu     = ($urandom_range(0, 2) == 0);
        r.need_caps    = pick_need_caps();
        return r;
    endfunction

    // directed requests keep random noise in the fields their mode ignores
    function automatic t_tb_req req_register(logic [WORKER_ID_W-1:0] id,
                                             logic [HANDLE_W-1:0] h,
                                             logic [MEMORY_W-1:0] mem,
                                             logic gpu, logic [CAPS_W-1:0] caps);
        t_tb_req r;
        r              = random_request(1);
        r.op           = OP_REGISTER;
        r.id           = id;
        r.handle       = h;
        r.agent_memory = mem;
        r.agent_gpu    = gpu;
        r.agent_caps   = caps;
        return r;
    endfunction

    function automatic t_tb_req req_handle(t_op op, logic [HANDLE_W-1:0] h);
        t_tb_req r;
        r        = random_request(1);
        r.op     = op;
        r.handle = h;
        return r;
    endfunction

    function automatic t_tb_req req_dispatch(logic [MEMORY_W-1:0] mem, logic gpu,
                                             logic [CAPS_W-1:0] caps);
        t_tb_req r;
        r             = random_request(1);
        r.op          = OP_DISPATCH;
        r.need_memory = mem;
        r.need_gpu    = gpu;
        r.need_caps   = caps;
        return r;
    endfunction

    function automatic void add_row(t_tb_req r, t_status st, logic [HANDLE_W-1:0] h,
                                    logic [SLOT_W-1:0] slot, logic [TOTAL_W-1:0] total);
        t_dir_row row;
        row.req             = r;
        row.hint.typed      = 1'b1;
        row.hint.rsp.status = st;
        row.hint.rsp.handle = h;
        row.hint.rsp.slot   = slot;
        row.hint.rsp.total  = total;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_free(t_tb_req r);
        t_dir_row row;
        row.req  = r;
        row.hint = '0;
        dir_rows.push_back(row);
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    function automatic int gap_cycles();
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(t_tb_req r, t_rsp_hint hint);
        req_if.valid        <= 1'b1;
        req_if.mode         <= r.op;
        req_if.worker_id    <= r.id;
        req_if.handle       <= r.handle;
        req_if.agent_memory <= r.agent_memory;
        req_if.agent_gpu    <= r.agent_gpu;
        req_if.agent_caps   <= r.agent_caps;
        req_if.need_memory  <= r.need_memory;
        req_if.need_gpu     <= r.need_gpu;
        req_if.need_caps    <= r.need_caps;
        hint_q.push_back(hint);
        @(posedge clk);
        while (req_if.ready !== 1'b1) @(posedge clk);
    endtask

    task automatic sender_gap();
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // request beats feed the model, response beats are checked against it
    always @(posedge clk) begin : beat_monitor
        t_tb_req   seen;
        t_tb_rsp   want;
        t_rsp_hint hint;
        bit        moved;
        if (!rst_n) begin
            idle_cycles = 0;
        end else begin
            moved = 1'b0;
            if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
                seen.op           = t_op'(req_if.mode);
                seen.id           = req_if.worker_id;
                seen.handle       = req_if.handle;
                seen.agent_memory = req_if.agent_memory;
                seen.agent_gpu    = req_if.agent_gpu;
                seen.agent_caps   = req_if.agent_caps;
                seen.need_memory  = req_if.need_memory;
                seen.need_gpu     = req_if.need_gpu;
                seen.need_caps    = req_if.need_caps;
                want              = table_step(seen);
                hint              = hint_q.pop_front();
                expected_rsp_q.push_back(hint.typed ? hint.rsp : want);
                moved             = 1'b1;
            end
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                moved = 1'b1;
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch($sformatf("response beat with nothing pending, status %0d",
                                              rsp_if.status));
                end else begin
                    want = expected_rsp_q.pop_front();
                    check_field("status", rsp_if.status, want.status);
                    check_field("chosen_handle", rsp_if.chosen_handle, want.handle);
                    check_field("chosen_slot", rsp_if.chosen_slot, want.slot);
                    check_field("agent_total", rsp_if.agent_total, want.total);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : response_sink
        int n;
        rsp_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (rsp_hold_req) begin
                // long back-pressure so the request side fills up and stalls
                rsp_hold_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                n = gap_cycles();
                if (n == 0) begin
                    rsp_if.ready <= 1'b1;
                    n = $urandom_range(1, 6);
                end else begin
                    rsp_if.ready <= 1'b0;
                end
                repeat (n) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int phase;
        int kind;
        rst_n               <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.mode         <= '0;
        req_if.worker_id    <= '0;
        req_if.handle       <= '0;
        req_if.agent_memory <= '0;
        req_if.agent_gpu    <= 1'b0;
        req_if.agent_caps   <= '0;
        req_if.need_memory  <= '0;
        req_if.need_gpu     <= 1'b0;
        req_if.need_caps    <= '0;
        tbl_count = 0;
        foreach (tbl_busy[i]) tbl_busy[i] = 1'b0;
        kind = 0;

        // empty table
        add_row(req_handle(OP_REMOVE, 16'h0000), ST_MISS, 16'h0000, 0, 0);
        add_row(req_handle(OP_RELEASE, 16'hFFFF), ST_MISS, 16'h0000, 0, 0);
        add_row(req_dispatch('0, 1'b0, '0), ST_MISS, 16'h0000, 0, 0);
        // smallest and largest agents, duplicate id
        add_row(req_register('0, 16'h0000, '0, 1'b0, '0), ST_DONE, 16'h0000, 0, 1);
        add_row(req_register('0, 16'h1234, '1, 1'b1, '1), ST_DUP, 16'h0000, 0, 1);
        add_row(req_register('1, 16'hFFFF, '1, 1'b1, '1), ST_DONE, 16'hFFFF, 1, 2);
        // hardest task only fits the big agent, easiest then takes the first
        add_row(req_dispatch('1, 1'b1, '1), ST_DONE, 16'hFFFF, 1, 2);
        add_row(req_dispatch('0, 1'b0, '0), ST_DONE, 16'h0000, 0, 2);
        // release twice, second one on a free agent
        add_row(req_handle(OP_RELEASE, 16'hFFFF), ST_DONE, 16'hFFFF, 1, 2);
        add_row(req_handle(OP_RELEASE, 16'hFFFF), ST_DONE, 16'hFFFF, 1, 2);
        // remove a busy agent, moved last agent stays free
        add_row(req_handle(OP_REMOVE, 16'h0000), ST_DONE, 16'h0000, 0, 1);
        add_row(req_dispatch('1, 1'b1, '1), ST_DONE, 16'hFFFF, 0, 1);
        // fill up, every other agent shares handle ffff
        for (int k = 1; k < DEPTH; k++)
            add_free(req_register(WORKER_ID_W'(32'h100 + k),
                                  (k % 2 == 0) ? 16'hFFFF : HANDLE_W'(k),
                                  MEMORY_W'(k << 16), k[0], CAPS_W'(1 << (k % 8))));
        add_row(req_register(32'hDEAD_0000, 16'h4321, '0, 1'b0, '0), ST_FULL, 16'h0000, 0,
                TOTAL_W'(DEPTH));
        // duplicate check wins over full table
        add_row(req_register(32'h105, 16'h4321, '0, 1'b0, '0), ST_DUP, 16'h0000, 0,
                TOTAL_W'(DEPTH));
        // repeated handle acts on the first agent only
        add_row(req_handle(OP_RELEASE, 16'hFFFF), ST_DONE, 16'hFFFF, 0, TOTAL_W'(DEPTH));
        add_row(req_handle(OP_REMOVE, 16'hFFFF), ST_DONE, 16'hFFFF, 0, TOTAL_W'(DEPTH - 1));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].req, dir_rows[i].hint);
            sender_gap();
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % PHASE_LEN == 0) begin
                phase = n / PHASE_LEN;
                kind  = phase % 3;
                quiet = (phase % 4 == 3) || (phase == HOLD_PHASE);
                if (phase == HOLD_PHASE) rsp_hold_req = 1'b1;
                if (phase == PAUSE_PHASE) begin
                    req_if.valid <= 1'b0;
                    @(posedge clk);
                    while (expected_rsp_q.size() != 0) @(posedge clk);
                end
            end
            send_request(random_request(kind), '0);
            sender_gap();
        end

        req_if.valid <= 1'b0;
        quiet = 1'b0;
        @(posedge clk);
        while (expected_rsp_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire
